// ----- sv/tcbp_pkg.sv -----
// Shared types, constants and register map for the thread cap balancing policy.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package tcbp_pkg;

  // Highest cap the policy may raise to, whatever max_threads says.
  localparam int MAX_THREAD_CAP = 256;

  // round(0.51 * 2^16), the margin numerator in Q0.16.
  localparam logic [15:0] MARGIN_Q16 = 16'd33423;

  // Configuration port geometry.
  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;

  // Register indexes (paddr[4:2]).
  localparam logic [2:0] REG_NUM_RANKS       = 3'd0;
  localparam logic [2:0] REG_MIN_THREADS     = 3'd1;
  localparam logic [2:0] REG_MAX_THREADS     = 3'd2;
  localparam logic [2:0] REG_INITIAL_THREADS = 3'd3;
  localparam logic [2:0] REG_WARMUP_TICKS    = 3'd4;

  // Register reset values.
  localparam logic [15:0] NUM_RANKS_RESET       = 16'd1;
  localparam logic [8:0]  MIN_THREADS_RESET     = 9'd1;
  localparam logic [8:0]  MAX_THREADS_RESET     = 9'd256;
  localparam logic [8:0]  INITIAL_THREADS_RESET = 9'd1;
  localparam logic [3:0]  WARMUP_TICKS_RESET    = 4'd10;

  // Command queue between the front and the back.
  localparam int CMD_DEPTH = 2;
  localparam int CMD_AW    = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
  localparam int CMD_CW    = $clog2(CMD_DEPTH + 1);

  // Shared divider geometry and per-division lengths.
  localparam int DIV_DW = 64;
  localparam int DIV_VW = 48;
  localparam int DIV_CW = 7;
  localparam logic [DIV_CW-1:0] LEN_TIME_SHARE   = 7'd64;
  localparam logic [DIV_CW-1:0] LEN_THREAD_SHARE = 7'd41;
  localparam logic [DIV_CW-1:0] LEN_MARGIN       = 7'd16;

  // Command kinds decided by the front.
  typedef logic [1:0] kind_t;
  localparam kind_t KIND_WARM   = 2'd0;
  localparam kind_t KIND_HOLD   = 2'd1;
  localparam kind_t KIND_ADJUST = 2'd2;

  // Action codes of a result.
  localparam logic [1:0] ACT_HELD   = 2'd0;
  localparam logic [1:0] ACT_RAISED = 2'd1;
  localparam logic [1:0] ACT_LOWERED = 2'd2;

  typedef struct packed {
    logic        profile_found;
    logic [31:0] accumulated_time;
    logic [23:0] thread_sum;
    logic [47:0] timer_sum;
  } in_item_t;

  typedef struct packed {
    logic [8:0]  active_threads;
    logic [31:0] period_time;
    logic        warming_up;
    logic [1:0]  action;
  } out_item_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] period;
    logic [23:0] thread_sum;
    logic [47:0] timer_sum;
  } cmd_t;

  // Configuration values plus load strobes for the state they preset.
  typedef struct packed {
    logic [15:0] num_ranks;
    logic [8:0]  min_threads;
    logic [8:0]  max_threads;
    logic [8:0]  initial_threads;
    logic [3:0]  warmup_ticks;
    logic        load_cap;
    logic        load_warm;
  } cfg_t;

endpackage

// ----- sv/tcbp_cmd_fifo.sv -----
// Short command queue that decouples the classifying front from the back.
// Depends on tcbp_pkg for the command type and depth.
`timescale 1ns / 1ps

module tcbp_cmd_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  tcbp_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          valid,
  output tcbp_pkg::cmd_t pop_data
);

  tcbp_pkg::cmd_t mem_r [tcbp_pkg::CMD_DEPTH];

  logic [tcbp_pkg::CMD_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [tcbp_pkg::CMD_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [tcbp_pkg::CMD_CW-1:0] count_r, count_nxt;
  logic                        do_push, do_pop;

  localparam logic [tcbp_pkg::CMD_AW-1:0] LAST_PTR =
    tcbp_pkg::CMD_AW'(tcbp_pkg::CMD_DEPTH - 1);
  localparam logic [tcbp_pkg::CMD_CW-1:0] FULL_COUNT =
    tcbp_pkg::CMD_CW'(tcbp_pkg::CMD_DEPTH);

  assign full     = (count_r == FULL_COUNT);
  assign valid    = (count_r != '0);
  assign pop_data = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- sv/tcbp_front.sv -----
// Front of the policy: takes tick transactions, tracks the time samples and
// warm-up countdown, and classifies each tick. Depends on tcbp_pkg.
`timescale 1ns / 1ps

module tcbp_front (
  input  logic               clk,
  input  logic               rst_n,
  input  tcbp_pkg::cfg_t     cfg,
  input  logic               in_push,
  output logic               in_full,
  input  tcbp_pkg::in_item_t in_item,
  output logic               cmd_push,
  output tcbp_pkg::cmd_t     cmd_data,
  input  logic               cmd_full
);

  logic [31:0] prior_r, prior_nxt;
  logic [31:0] latest_r, latest_nxt;
  logic [3:0]  warm_left_r, warm_left_nxt;
  logic        accept;

  assign in_full  = cmd_full;
  assign accept   = in_push && !cmd_full;
  assign cmd_push = accept;

  // Sample shift, period time and classification of the tick.
  always_comb begin
    prior_nxt     = prior_r;
    latest_nxt    = latest_r;
    warm_left_nxt = warm_left_r;
    if (in_item.profile_found) begin
      prior_nxt  = latest_r;
      latest_nxt = in_item.accumulated_time;
    end

    cmd_data.period     = latest_nxt - prior_nxt;
    cmd_data.thread_sum = in_item.thread_sum;
    cmd_data.timer_sum  = in_item.timer_sum;
    if (warm_left_r != 4'd0) begin
      cmd_data.kind = tcbp_pkg::KIND_WARM;
      warm_left_nxt = warm_left_r - 4'd1;
    end else if (in_item.thread_sum != '0 && in_item.timer_sum != '0) begin
      cmd_data.kind = tcbp_pkg::KIND_ADJUST;
    end else begin
      cmd_data.kind = tcbp_pkg::KIND_HOLD;
    end

    if (!accept) begin
      prior_nxt     = prior_r;
      latest_nxt    = latest_r;
      warm_left_nxt = warm_left_r;
    end
    // A warm-up register write reloads the countdown; user keeps block idle (unchecked).
    if (cfg.load_warm) begin
      warm_left_nxt = cfg.warmup_ticks;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prior_r     <= '0;
      latest_r    <= '0;
      warm_left_r <= tcbp_pkg::WARMUP_TICKS_RESET;
    end else begin
      prior_r     <= prior_nxt;
      latest_r    <= latest_nxt;
      warm_left_r <= warm_left_nxt;
    end
  end

endmodule

// ----- sv/tcbp_divider.sv -----
// Shared restoring divider, one quotient bit per cycle.
// The dividend comes left aligned; len bits are developed. Depends on tcbp_pkg.
`timescale 1ns / 1ps

module tcbp_divider (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [tcbp_pkg::DIV_DW-1:0]   dividend,
  input  logic [tcbp_pkg::DIV_VW-1:0]   divisor,
  input  logic [tcbp_pkg::DIV_CW-1:0]   len,
  output logic                          done,
  output logic [tcbp_pkg::DIV_DW-1:0]   quotient
);

  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [tcbp_pkg::DIV_CW-1:0] cnt_r, cnt_nxt;
  logic [tcbp_pkg::DIV_VW-1:0] rem_r, rem_nxt;
  logic [tcbp_pkg::DIV_VW-1:0] dvs_r, dvs_nxt;
  logic [tcbp_pkg::DIV_DW-1:0] quo_r, quo_nxt;
  logic [tcbp_pkg::DIV_VW:0]   trial, diff;

  assign done     = done_r;
  assign quotient = quo_r;

  // One trial subtraction per cycle.
  always_comb begin
    trial    = {rem_r, quo_r[tcbp_pkg::DIV_DW-1]};
    diff     = trial - {1'b0, dvs_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = len;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      if (!diff[tcbp_pkg::DIV_VW]) begin
        rem_nxt = diff[tcbp_pkg::DIV_VW-1:0];
        quo_nxt = {quo_r[tcbp_pkg::DIV_DW-2:0], 1'b1};
      end else begin
        rem_nxt = trial[tcbp_pkg::DIV_VW-1:0];
        quo_nxt = {quo_r[tcbp_pkg::DIV_DW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == tcbp_pkg::DIV_CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    quo_r <= quo_nxt;
  end

endmodule

// ----- sv/tcbp_back.sv -----
// Back of the policy: runs each command, computes the Q48.16 time share, the
// Q25.16 thread share and the margin on the shared divider, and steps the
// thread cap. Depends on tcbp_pkg and tcbp_divider.
`timescale 1ns / 1ps

module tcbp_back (
  input  logic                clk,
  input  logic                rst_n,
  input  tcbp_pkg::cfg_t      cfg,
  input  logic                cmd_valid,
  input  tcbp_pkg::cmd_t      cmd,
  output logic                cmd_pop,
  input  logic                out_pop,
  output logic                out_empty,
  output tcbp_pkg::out_item_t out_item
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_MUL     = 4'd1;
  localparam logic [3:0] S_TS_GO   = 4'd2;
  localparam logic [3:0] S_TS_WAIT = 4'd3;
  localparam logic [3:0] S_HS_GO   = 4'd4;
  localparam logic [3:0] S_HS_WAIT = 4'd5;
  localparam logic [3:0] S_M_GO    = 4'd6;
  localparam logic [3:0] S_M_WAIT  = 4'd7;
  localparam logic [3:0] S_DECIDE  = 4'd8;

  logic [3:0]          state_r, state_nxt;
  logic [8:0]          cap_r, cap_nxt;
  tcbp_pkg::cmd_t      cmd_r, cmd_nxt;
  logic [47:0]         prod_t_r, prod_t_nxt;
  logic [24:0]         prod_h_r, prod_h_nxt;
  logic [63:0]         ts_r, ts_nxt;
  logic [40:0]         hs_r, hs_nxt;
  logic [15:0]         m_r, m_nxt;
  logic                out_valid_r, out_valid_nxt;
  tcbp_pkg::out_item_t out_item_r, out_item_nxt;

  logic                          div_start;
  logic [tcbp_pkg::DIV_DW-1:0]   div_dividend;
  logic [tcbp_pkg::DIV_VW-1:0]   div_divisor;
  logic [tcbp_pkg::DIV_CW-1:0]   div_len;
  logic                          div_done;
  logic [tcbp_pkg::DIV_DW-1:0]   div_quo;

  logic        out_free;
  logic [63:0] hs_plus_m, ts_plus_m;
  logic        can_raise, can_lower, want_raise, want_lower;
  logic [8:0]  margin_div;

  assign out_empty = !out_valid_r;
  assign out_item  = out_item_r;
  assign out_free  = !out_valid_r || out_pop;

  tcbp_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .len      (div_len),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Share comparison with margin, and limit checks on the cap.
  always_comb begin
    hs_plus_m  = {23'b0, hs_r} + {48'b0, m_r};
    ts_plus_m  = ts_r + {48'b0, m_r};
    can_raise  = (cap_r < cfg.max_threads) && (int'(cap_r) < tcbp_pkg::MAX_THREAD_CAP);
    can_lower  = (cap_r > cfg.min_threads);
    want_raise = (ts_r > hs_plus_m) && can_raise;
    want_lower = !want_raise && (ts_plus_m < {23'b0, hs_r}) && can_lower;
    margin_div = (cap_r == 9'd0) ? 9'd1 : cap_r;
  end

  // Command sequencer.
  always_comb begin
    state_nxt     = state_r;
    cap_nxt       = cap_r;
    cmd_nxt       = cmd_r;
    prod_t_nxt    = prod_t_r;
    prod_h_nxt    = prod_h_r;
    ts_nxt        = ts_r;
    hs_nxt        = hs_r;
    m_nxt         = m_r;
    out_valid_nxt = out_valid_r && !out_pop;
    out_item_nxt  = out_item_r;
    cmd_pop       = 1'b0;
    div_start     = 1'b0;
    div_dividend  = '0;
    div_divisor   = '0;
    div_len       = '0;

    case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          if (cmd.kind == tcbp_pkg::KIND_ADJUST) begin
            cmd_pop   = 1'b1;
            cmd_nxt   = cmd;
            state_nxt = S_MUL;
          end else if (out_free) begin
            // Warm-up and zero-sum ticks report the cap as it stands.
            cmd_pop                     = 1'b1;
            out_valid_nxt               = 1'b1;
            out_item_nxt.active_threads = cap_r;
            out_item_nxt.period_time    = cmd.period;
            out_item_nxt.warming_up     = (cmd.kind == tcbp_pkg::KIND_WARM);
            out_item_nxt.action         = tcbp_pkg::ACT_HELD;
          end
        end
      end
      S_MUL: begin
        prod_t_nxt = cmd_r.period * cfg.num_ranks;
        prod_h_nxt = cap_r * cfg.num_ranks;
        state_nxt  = S_TS_GO;
      end
      S_TS_GO: begin
        div_start    = 1'b1;
        div_dividend = {prod_t_r, 16'b0};
        div_divisor  = cmd_r.timer_sum;
        div_len      = tcbp_pkg::LEN_TIME_SHARE;
        state_nxt    = S_TS_WAIT;
      end
      S_TS_WAIT: begin
        if (div_done) begin
          ts_nxt    = div_quo;
          state_nxt = S_HS_GO;
        end
      end
      S_HS_GO: begin
        div_start    = 1'b1;
        div_dividend = {prod_h_r, 16'b0, 23'b0};
        div_divisor  = {24'b0, cmd_r.thread_sum};
        div_len      = tcbp_pkg::LEN_THREAD_SHARE;
        state_nxt    = S_HS_WAIT;
      end
      S_HS_WAIT: begin
        if (div_done) begin
          hs_nxt    = div_quo[40:0];
          state_nxt = S_M_GO;
        end
      end
      S_M_GO: begin
        div_start    = 1'b1;
        div_dividend = {tcbp_pkg::MARGIN_Q16, 48'b0};
        div_divisor  = {39'b0, margin_div};
        div_len      = tcbp_pkg::LEN_MARGIN;
        state_nxt    = S_M_WAIT;
      end
      S_M_WAIT: begin
        if (div_done) begin
          m_nxt     = div_quo[15:0];
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_item_nxt.period_time = cmd_r.period;
          out_item_nxt.warming_up  = 1'b0;
          if (want_raise) begin
            cap_nxt             = cap_r + 9'd1;
            out_item_nxt.action = tcbp_pkg::ACT_RAISED;
          end else if (want_lower) begin
            cap_nxt             = cap_r - 9'd1;
            out_item_nxt.action = tcbp_pkg::ACT_LOWERED;
          end else begin
            out_item_nxt.action = tcbp_pkg::ACT_HELD;
          end
          out_item_nxt.active_threads = cap_nxt;
          state_nxt                   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Writing initial_threads presets the cap; user keeps block idle (unchecked).
    if (cfg.load_cap) begin
      cap_nxt = cfg.initial_threads;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cap_r       <= tcbp_pkg::INITIAL_THREADS_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cap_r       <= cap_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers need no reset.
  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    prod_t_r   <= prod_t_nxt;
    prod_h_r   <= prod_h_nxt;
    ts_r       <= ts_nxt;
    hs_r       <= hs_nxt;
    m_r        <= m_nxt;
    out_item_r <= out_item_nxt;
  end

endmodule

// ----- sv/thread_cap_balance_policy.sv -----
// Top level of the thread cap balancing policy: configuration registers and
// the front, command queue and back. Depends on tcbp_pkg and all tcbp modules.
//
//   Channel   Handshake                      Payload
//   input     push / full (accept on ~full)  in_item  (tcbp_pkg::in_item_t)
//   result    empty / pop (accept on ~empty) out_item (tcbp_pkg::out_item_t)
//   config    psel, penable, pwrite, pready  paddr[4:2] index, pwdata, prdata
//
// A warm-up or zero-sum tick reaches the result ports via the command queue and output
// register. An adjusting tick runs the back's multiply state, then a setup and a wait
// state per time share, thread share and margin division on the one shared divider.
// The front keeps taking ticks while the two-entry command queue has room.
// Synchronous active-low reset clears control state and loads register resets.
// A result in the output register stalls the back, and the front once the queue fills.
`timescale 1ns / 1ps

module thread_cap_balance_policy (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tcbp_pkg::CFG_AW-1:0]   paddr,
  input  logic [tcbp_pkg::CFG_DW-1:0]   pwdata,
  output logic [tcbp_pkg::CFG_DW-1:0]   prdata,
  output logic                          pready,
  input  logic                          push,
  output logic                          full,
  input  tcbp_pkg::in_item_t            in_item,
  output logic                          empty,
  input  logic                          pop,
  output tcbp_pkg::out_item_t           out_item
);

  logic [15:0] num_ranks_r, num_ranks_nxt;
  logic [8:0]  min_threads_r, min_threads_nxt;
  logic [8:0]  max_threads_r, max_threads_nxt;
  logic [8:0]  initial_threads_r, initial_threads_nxt;
  logic [3:0]  warmup_ticks_r, warmup_ticks_nxt;

  logic           cfg_wr;
  logic [2:0]     cfg_idx;
  tcbp_pkg::cfg_t cfg;

  logic           cmd_push, cmd_full, cmd_pop, cmd_valid;
  tcbp_pkg::cmd_t cmd_in, cmd_out;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[4:2];

  // Register write decode.
  always_comb begin
    num_ranks_nxt       = num_ranks_r;
    min_threads_nxt     = min_threads_r;
    max_threads_nxt     = max_threads_r;
    initial_threads_nxt = initial_threads_r;
    warmup_ticks_nxt    = warmup_ticks_r;
    cfg.load_cap        = 1'b0;
    cfg.load_warm       = 1'b0;
    if (cfg_wr) begin
      case (cfg_idx)
        tcbp_pkg::REG_NUM_RANKS:   num_ranks_nxt   = pwdata[15:0];
        tcbp_pkg::REG_MIN_THREADS: min_threads_nxt = pwdata[8:0];
        tcbp_pkg::REG_MAX_THREADS: max_threads_nxt = pwdata[8:0];
        tcbp_pkg::REG_INITIAL_THREADS: begin
          initial_threads_nxt = pwdata[8:0];
          cfg.load_cap        = 1'b1;
        end
        tcbp_pkg::REG_WARMUP_TICKS: begin
          warmup_ticks_nxt = pwdata[3:0];
          cfg.load_warm    = 1'b1;
        end
        default: begin
        end
      endcase
    end
    // Load strobes carry the freshly written values.
    cfg.num_ranks       = num_ranks_r;
    cfg.min_threads     = min_threads_r;
    cfg.max_threads     = max_threads_r;
    cfg.initial_threads = initial_threads_nxt;
    cfg.warmup_ticks    = warmup_ticks_nxt;
  end

  // Register read mux.
  always_comb begin
    case (cfg_idx)
      tcbp_pkg::REG_NUM_RANKS:       prdata = {16'b0, num_ranks_r};
      tcbp_pkg::REG_MIN_THREADS:     prdata = {23'b0, min_threads_r};
      tcbp_pkg::REG_MAX_THREADS:     prdata = {23'b0, max_threads_r};
      tcbp_pkg::REG_INITIAL_THREADS: prdata = {23'b0, initial_threads_r};
      tcbp_pkg::REG_WARMUP_TICKS:    prdata = {28'b0, warmup_ticks_r};
      default:                       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_ranks_r       <= tcbp_pkg::NUM_RANKS_RESET;
      min_threads_r     <= tcbp_pkg::MIN_THREADS_RESET;
      max_threads_r     <= tcbp_pkg::MAX_THREADS_RESET;
      initial_threads_r <= tcbp_pkg::INITIAL_THREADS_RESET;
      warmup_ticks_r    <= tcbp_pkg::WARMUP_TICKS_RESET;
    end else begin
      num_ranks_r       <= num_ranks_nxt;
      min_threads_r     <= min_threads_nxt;
      max_threads_r     <= max_threads_nxt;
      initial_threads_r <= initial_threads_nxt;
      warmup_ticks_r    <= warmup_ticks_nxt;
    end
  end

  tcbp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_push  (push),
    .in_full  (full),
    .in_item  (in_item),
    .cmd_push (cmd_push),
    .cmd_data (cmd_in),
    .cmd_full (cmd_full)
  );

  tcbp_cmd_fifo u_cmd_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cmd_push),
    .push_data (cmd_in),
    .full      (cmd_full),
    .pop       (cmd_pop),
    .valid     (cmd_valid),
    .pop_data  (cmd_out)
  );

  tcbp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .cmd_valid (cmd_valid),
    .cmd       (cmd_out),
    .cmd_pop   (cmd_pop),
    .out_pop   (pop),
    .out_empty (empty),
    .out_item  (out_item)
  );

endmodule

// ----- verif/thread_cap_balance_policy_tb.sv -----
// Self-checking testbench for the thread cap balancing policy block.
// Depends on tcbp_pkg and thread_cap_balance_policy; drives ticks, checks every
// result against a cycle-free model of the policy kept inside this file.
`timescale 1ns / 1ps

module thread_cap_balance_policy_tb;

  // Register indexes with nothing behind them; writes there must be ignored.
  localparam logic [2:0] REG_SPARE_LO = 3'd5;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  // Length of the long receiver hold-off used to back up the block.
  localparam int HOLD_CYCLES = 1500;

  // Ticks per random phase and number of random phases.
  localparam int PHASE_TICKS = 100;
  localparam int NUM_PHASES  = 8;

  logic                          clk     = 1'b0;
  logic                          rst_n   = 1'b0;
  logic                          psel    = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite  = 1'b0;
  logic [tcbp_pkg::CFG_AW-1:0]   paddr   = '0;
  logic [tcbp_pkg::CFG_DW-1:0]   pwdata  = '0;
  logic [tcbp_pkg::CFG_DW-1:0]   prdata;
  logic                          pready;
  logic                          push    = 1'b0;
  logic                          full;
  tcbp_pkg::in_item_t            in_item = '0;
  logic                          empty;
  logic                          pop     = 1'b0;
  tcbp_pkg::out_item_t           out_item;

  // Mirror of the configuration registers.
  logic [15:0] r_num_ranks;
  logic [8:0]  r_min;
  logic [8:0]  r_max;
  logic [8:0]  r_init;
  logic [3:0]  r_warmup;

  // Mirror of the policy state.
  logic [8:0]  cap_q;
  logic [31:0] smp_prior;
  logic [31:0] smp_latest;
  logic [3:0]  warm_left;

  // Results still owed by the block, oldest first.
  tcbp_pkg::out_item_t expected_results[$];

  int n_fail     = 0;
  int n_sent     = 0;
  int n_checked  = 0;
  int n_raised   = 0;
  int n_lowered  = 0;
  int n_warm     = 0;
  int n_settings = 0;

  // Long hold-off requests from the test sequence, served by the receiver.
  int hold_reqs   = 0;
  int hold_served = 0;
  int rx_hold     = 0;
  int rx_cycle    = 0;

  thread_cap_balance_policy dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

  always #1 clk = ~clk;

  // Hard limit on run length.
  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // Load the state the block has after reset.
  function automatic void reset_policy_state();
    r_num_ranks = tcbp_pkg::NUM_RANKS_RESET;
    r_min       = tcbp_pkg::MIN_THREADS_RESET;
    r_max       = tcbp_pkg::MAX_THREADS_RESET;
    r_init      = tcbp_pkg::INITIAL_THREADS_RESET;
    r_warmup    = tcbp_pkg::WARMUP_TICKS_RESET;
    cap_q       = r_init;
    smp_prior   = '0;
    smp_latest  = '0;
    warm_left   = r_warmup;
  endfunction

  // One policy tick: update the sample pair, then warm up, hold or adjust the cap.
  function automatic tcbp_pkg::out_item_t policy_tick(tcbp_pkg::in_item_t it);
    tcbp_pkg::out_item_t r;
    logic [63:0] t_share;
    logic [63:0] h_share;
    logic [63:0] margin;
    logic [8:0]  upper;
    if (it.profile_found) begin
      smp_prior  = smp_latest;
      smp_latest = it.accumulated_time;
    end
    r.period_time = smp_latest - smp_prior;
    r.warming_up  = 1'b0;
    r.action      = tcbp_pkg::ACT_HELD;
    if (warm_left != 4'd0) begin
      warm_left    = warm_left - 4'd1;
      r.warming_up = 1'b1;
      n_warm++;
    end else if (it.thread_sum != '0 && it.timer_sum != '0) begin
      t_share = ((64'(r.period_time) * 64'(r_num_ranks)) << 16) / 64'(it.timer_sum);
      h_share = ((64'(cap_q) * 64'(r_num_ranks)) << 16) / 64'(it.thread_sum);
      margin  = 64'(tcbp_pkg::MARGIN_Q16) / 64'((cap_q == 9'd0) ? 9'd1 : cap_q);
      upper   = (r_max > tcbp_pkg::MAX_THREAD_CAP) ? 9'(tcbp_pkg::MAX_THREAD_CAP) : r_max;
      // Raising is tested first; the two share tests cannot both hold, even with crossed limits.
      if (65'(t_share) > 65'(h_share) + 65'(margin) && cap_q < upper) begin
        cap_q    = cap_q + 9'd1;
        r.action = tcbp_pkg::ACT_RAISED;
        n_raised++;
      end else if (65'(t_share) + 65'(margin) < 65'(h_share) && cap_q > r_min) begin
        cap_q    = cap_q - 9'd1;
        r.action = tcbp_pkg::ACT_LOWERED;
        n_lowered++;
      end
    end
    r.active_threads = cap_q;
    return r;
  endfunction

  // A tick whose sums sit near this node's own shares, so the cap moves both ways.
  function automatic tcbp_pkg::in_item_t shaped_tick();
    tcbp_pkg::in_item_t it;
    logic [31:0] delta;
    logic [31:0] period;
    logic [63:0] want_sum;
    logic [8:0]  c;
    it.profile_found = ($urandom_range(0, 9) != 0);
    delta = ($urandom_range(0, 7) == 0) ? 32'($urandom) : 32'($urandom_range(1, 200000));
    it.accumulated_time = smp_latest + delta;
    period = it.profile_found ? delta : (smp_latest - smp_prior);
    c = (cap_q == 9'd0) ? 9'd1 : cap_q;
    want_sum = (64'(c) * 64'(r_num_ranks) * 64'($urandom_range(60, 160))) / 64'd100;
    if (want_sum == 64'd0) want_sum = 64'd1;
    if (want_sum > 64'hFF_FFFF) want_sum = 64'hFF_FFFF;
    it.thread_sum = want_sum[23:0];
    want_sum = (64'(period) * 64'(r_num_ranks) * 64'($urandom_range(60, 160))) / 64'd100;
    if (want_sum == 64'd0) want_sum = 64'd1;
    if (want_sum > 64'hFFFF_FFFF_FFFF) want_sum = 64'hFFFF_FFFF_FFFF;
    it.timer_sum = want_sum[47:0];
    // Now and then one of the sums is missing.
    if ($urandom_range(0, 19) == 0) begin
      if ($urandom_range(0, 1) == 1) it.thread_sum = '0;
      else it.timer_sum = '0;
    end
    return it;
  endfunction

  // A tick with unrelated random content.
  function automatic tcbp_pkg::in_item_t noise_tick();
    tcbp_pkg::in_item_t it;
    it.profile_found    = 1'($urandom_range(0, 1));
    it.accumulated_time = $urandom;
    it.thread_sum = ($urandom_range(0, 1) == 1) ? 24'($urandom) : 24'($urandom_range(0, 1023));
    it.timer_sum  = ($urandom_range(0, 1) == 1) ? {16'($urandom), 32'($urandom)}
                                                : 48'($urandom_range(0, 100000));
    return it;
  endfunction

  // Register write: setup cycle, then access cycle; the write lands at its end.
  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      tcbp_pkg::REG_NUM_RANKS:   r_num_ranks = val[15:0];
      tcbp_pkg::REG_MIN_THREADS: r_min = val[8:0];
      tcbp_pkg::REG_MAX_THREADS: r_max = val[8:0];
      tcbp_pkg::REG_INITIAL_THREADS: begin
        r_init = val[8:0];
        cap_q  = r_init;
      end
      tcbp_pkg::REG_WARMUP_TICKS: begin
        r_warmup  = val[3:0];
        warm_left = r_warmup;
      end
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Offer one tick and wait for the transaction; push stays high on return.
  task automatic send_tick(tcbp_pkg::in_item_t it);
    in_item <= it;
    push    <= 1'b1;
    do @(posedge clk); while (full);
    expected_results.push_back(policy_tick(it));
    n_sent++;
  endtask

  task automatic tick(logic f, logic [31:0] acc, logic [23:0] tsum, logic [47:0] msum);
    tcbp_pkg::in_item_t it;
    it.profile_found    = f;
    it.accumulated_time = acc;
    it.thread_sum       = tsum;
    it.timer_sum        = msum;
    send_tick(it);
  endtask

  task automatic pause_sender(int n);
    push <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Stop sending and wait until every owed result has been taken.
  task automatic drain();
    pause_sender(1);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Go idle, then write all five registers; upper bits carry junk.
  task automatic set_policy(logic [15:0] nr, logic [8:0] mn, logic [8:0] mx,
                            logic [8:0] init, logic [3:0] warm);
    drain();
    reg_write(tcbp_pkg::REG_NUM_RANKS,       {16'($urandom), nr});
    reg_write(tcbp_pkg::REG_MIN_THREADS,     {23'($urandom), mn});
    reg_write(tcbp_pkg::REG_MAX_THREADS,     {23'($urandom), mx});
    reg_write(tcbp_pkg::REG_INITIAL_THREADS, {23'($urandom), init});
    reg_write(tcbp_pkg::REG_WARMUP_TICKS,    {28'($urandom), warm});
    n_settings++;
  endtask

  // Reset values: ten warm-up ticks at cap 1, sample wrap, then adjusting starts.
  task automatic test_reset_defaults();
    tick(1'b1, 32'd100, 24'd1, 48'd100);
    tick(1'b0, 32'd999, 24'd1, 48'd100);
    tick(1'b1, 32'd50, 24'd1, 48'd100);
    tick(1'b1, 32'hFFFF_FFFF, 24'd1, 48'd100);
    tick(1'b1, 32'd0, 24'd1, 48'd100);
    repeat (5) tick(1'b1, smp_latest + 32'd10, 24'd1, 48'd10);
    tick(1'b1, smp_latest + 32'd10, 24'd1, 48'd10);
    tick(1'b1, smp_latest + 32'd10, 24'd1, 48'd1);
  endtask

  // Zero sums, all-ones fields, rank and cap extremes, crossed limits.
  task automatic test_directed_corners();
    set_policy(16'd1, 9'd1, 9'd256, 9'd8, 4'd0);
    tick(1'b1, smp_latest + 32'd1000, 24'd8, 48'd0);
    tick(1'b1, smp_latest + 32'd1000, 24'd0, 48'd1000);
    tick(1'b1, smp_latest + 32'd1000, 24'd8, 48'd500);
    tick(1'b1, smp_latest + 32'd4000, 24'd9, 48'd16000);
    tick(1'b1, 32'hFFFF_FFFF, 24'hFF_FFFF, 48'hFFFF_FFFF_FFFF);
    // Ranks at maximum, max above the hard cap, widest period.
    set_policy(16'hFFFF, 9'd1, 9'd511, 9'd255, 4'd0);
    tick(1'b1, smp_latest - 32'd1, 24'd1, 48'd1);
    tick(1'b1, smp_latest - 32'd1, 24'd1, 48'd1);
    // Zero ranks make both shares zero.
    set_policy(16'd0, 9'd1, 9'd256, 9'd8, 4'd0);
    tick(1'b1, smp_latest + 32'd1000, 24'd8, 48'd1);
    // Zero cap: margin divides by one.
    set_policy(16'd1, 9'd1, 9'd256, 9'd0, 4'd0);
    tick(1'b1, smp_latest + 32'd1000, 24'd1, 48'd1);
    // Cap above the hard limit can only come down.
    set_policy(16'd1, 9'd1, 9'd256, 9'd511, 4'd0);
    tick(1'b1, smp_latest + 32'd1, 24'd1, 48'hFFFF_FFFF_FFFF);
    // Min above max, cap between and then below both.
    set_policy(16'd1, 9'd200, 9'd100, 9'd150, 4'd0);
    tick(1'b1, smp_latest + 32'd1000, 24'hFF_FFFF, 48'd1);
    tick(1'b1, smp_latest + 32'd1, 24'd1, 48'hFFFF_FFFF_FFFF);
    set_policy(16'd1, 9'd200, 9'd100, 9'd50, 4'd0);
    tick(1'b1, smp_latest + 32'd1000, 24'hFF_FFFF, 48'd1);
    tick(1'b1, smp_latest + 32'd1, 24'd1, 48'hFFFF_FFFF_FFFF);
    // Writes to unmapped indexes change nothing.
    drain();
    reg_write(REG_SPARE_LO, $urandom);
    reg_write(REG_SPARE_HI, $urandom);
    tick(1'b1, smp_latest + 32'd1000, 24'hFF_FFFF, 48'd1);
  endtask

  // Receiver holds off for a long stretch while ticks keep coming.
  task automatic test_input_stall();
    set_policy(16'd1, 9'd1, 9'd256, 9'd64, 4'd0);
    hold_reqs <= hold_reqs + 1;
    repeat (40) send_tick(shaped_tick());
  endtask

  // Random phases: new settings each phase, bursty ticks, mostly shaped content.
  task automatic test_random_phases();
    int       sent;
    int       burst;
    logic [8:0] mn;
    logic [8:0] mx;
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: set_policy(16'd1, 9'd1, 9'd256, 9'd1, 4'd0);
        1: set_policy(16'hFFFF, 9'd256, 9'd511, 9'd256, 4'd15);
        2: set_policy(16'($urandom_range(1, 4)), 9'($urandom_range(100, 200)),
                      9'($urandom_range(1, 99)), 9'($urandom), 4'($urandom_range(0, 15)));
        default: begin
          mn = 9'($urandom_range(1, 16));
          mx = 9'($urandom_range(17, 300));
          set_policy(16'($urandom_range(1, 16)), mn, mx, 9'($urandom_range(mn, mx)),
                     4'($urandom_range(0, 15)));
        end
      endcase
      sent = 0;
      while (sent < PHASE_TICKS) begin
        burst = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
        for (int i = 0; i < burst && sent < PHASE_TICKS; i++) begin
          send_tick(($urandom_range(0, 3) == 0) ? noise_tick() : shaped_tick());
          sent++;
        end
        pause_sender($urandom_range(1, 10));
      end
    end
  endtask

  // Receiver: stall pattern steps through four modes in turn; long hold-offs on request.
  always @(posedge clk) begin
    rx_cycle++;
    if (hold_reqs != hold_served) begin
      hold_served = hold_reqs;
      rx_hold     = HOLD_CYCLES;
    end
    if (!rst_n) begin
      pop <= 1'b0;
    end else if (rx_hold > 0) begin
      rx_hold--;
      pop <= 1'b0;
    end else begin
      case ((rx_cycle / 97) % 4)
        0:       pop <= 1'b1;
        1:       pop <= ($urandom_range(0, 1) == 1);
        2:       pop <= ($urandom_range(0, 3) != 0);
        default: pop <= ((rx_cycle % 16) < 3);
      endcase
    end
  end

  // Compare each result transaction with the oldest owed result.
  always @(posedge clk) begin
    tcbp_pkg::out_item_t want;
    if (rst_n && pop && !empty) begin
      if (expected_results.size() == 0) begin
        $error("result transaction with no tick waiting: %h", out_item);
        n_fail++;
      end else begin
        want = expected_results.pop_front();
        n_checked++;
        if (out_item.active_threads !== want.active_threads) begin
          $error("active_threads: expected %0d, got %0d", want.active_threads,
                 out_item.active_threads);
          n_fail++;
        end
        if (out_item.period_time !== want.period_time) begin
          $error("period_time: expected %h, got %h", want.period_time, out_item.period_time);
          n_fail++;
        end
        if (out_item.warming_up !== want.warming_up) begin
          $error("warming_up: expected %b, got %b", want.warming_up, out_item.warming_up);
          n_fail++;
        end
        if (out_item.action !== want.action) begin
          $error("action: expected %0d, got %0d", want.action, out_item.action);
          n_fail++;
        end
      end
    end
  end

  // Test sequence.
  initial begin
    reset_policy_state();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_directed_corners();
    test_input_stall();
    test_random_phases();
    drain();
    repeat (20) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d results never arrived", expected_results.size());
      n_fail++;
    end
    $display("Ran %0d policy ticks under %0d register settings, %0d results checked.",
             n_sent, n_settings, n_checked);
    $display("Caps raised %0d times, lowered %0d times; %0d warm-up ticks.",
             n_raised, n_lowered, n_warm);
    if (n_fail == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
